### src/lsbe_pkg.sv
// Shared types and constants for the LSB steganography bit extractor.
package lsbe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TAKE_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LSBE_MODE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SAMPLE = 2'd2;

    localparam logic [1:0] TAKE_1BIT = 2'd0;
    localparam logic [1:0] TAKE_2BIT = 2'd1;
    localparam logic [1:0] TAKE_4BIT = 2'd2;

    localparam logic [7:0] MASK_1BIT = 8'h01;
    localparam logic [7:0] MASK_2BIT = 8'h03;
    localparam logic [7:0] MASK_4BIT = 8'h0f;
    localparam logic [7:0] LSBE_MARK = 8'hFF;

    localparam logic [3:0] BPS_RESET = 4'd2;
    localparam logic [3:0] BPS_MAX   = 4'd8;

    typedef struct packed {
        logic [1:0] take_mode;
        logic       lsbe_mode;
        logic [3:0] bytes_per_sample;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_complete;
        logic       final_result;
    } t_result;

endpackage

### src/lsbe_cfg_regs.sv
// Configuration registers of the extractor.
module lsbe_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lsbe_pkg::t_cfg                 o_cfg
);
    import lsbe_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TAKE_MODE:        n_cfg.take_mode        = i_cfg_data[1:0];
                CFG_LSBE_MODE:        n_cfg.lsbe_mode        = i_cfg_data[0];
                CFG_BYTES_PER_SAMPLE: n_cfg.bytes_per_sample = i_cfg_data[3:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.take_mode        <= TAKE_1BIT;
            r_cfg.lsbe_mode        <= 1'b0;
            r_cfg.bytes_per_sample <= BPS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/lsbe_bit_packer.sv
// Bit selection and MSB-first packing, with the per-stream state registers.
module lsbe_bit_packer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsbe_pkg::t_cfg   i_cfg,
    input  logic             i_accept,
    input  logic [7:0]       i_sample_byte,
    input  logic             i_stream_end,
    output logic             o_has_result,
    output lsbe_pkg::t_result o_result
);
    import lsbe_pkg::*;

    logic [2:0] r_byte_position, n_byte_position;
    logic [7:0] r_bit_accumulator, n_bit_accumulator;
    logic [2:0] r_bits_collected, n_bits_collected;

    logic [2:0] nbits;
    logic [3:0] bits;
    logic [7:0] acc;
    logic [2:0] cnt;
    logic       full;
    logic [7:0] full_val;
    logic [3:0] frame_len;
    logic [3:0] pos_inc;

    // Choose the bits this word gives.
    always_comb begin
        nbits = 3'd0;
        bits  = 4'd0;
        if (i_cfg.lsbe_mode) begin
            if ((i_sample_byte | MASK_1BIT) == LSBE_MARK) begin
                nbits = 3'd1;
                bits  = {3'b000, i_sample_byte[0]};
            end
        end else if (r_byte_position == 3'd0) begin
            case (i_cfg.take_mode)
                TAKE_1BIT: begin
                    nbits = 3'd1;
                    bits  = 4'(i_sample_byte & MASK_1BIT);
                end
                TAKE_2BIT: begin
                    nbits = 3'd2;
                    bits  = 4'(i_sample_byte & MASK_2BIT);
                end
                TAKE_4BIT: begin
                    nbits = 3'd4;
                    bits  = 4'(i_sample_byte & MASK_4BIT);
                end
                default: begin
                    nbits = 3'd0;
                    bits  = 4'd0;
                end
            endcase
        end
    end

    // Insert up to four bits, most significant first. At most one byte can fill.
    always_comb begin
        acc      = r_bit_accumulator;
        cnt      = r_bits_collected;
        full     = 1'b0;
        full_val = 8'd0;
        for (int i = 3; i >= 0; i--) begin
            if (3'(i) < nbits) begin
                acc[3'd7 - cnt] = bits[2'(i)];
                if (cnt == 3'd7) begin
                    if (!full) begin
                        full     = 1'b1;
                        full_val = acc;
                    end
                    acc = 8'd0;
                    cnt = 3'd0;
                end else begin
                    cnt = cnt + 3'd1;
                end
            end
        end
    end

    always_comb begin
        if (i_cfg.bytes_per_sample == 4'd0) begin
            frame_len = 4'd1;
        end else if (i_cfg.bytes_per_sample > BPS_MAX) begin
            frame_len = BPS_MAX;
        end else begin
            frame_len = i_cfg.bytes_per_sample;
        end
        pos_inc = {1'b0, r_byte_position} + 4'd1;
    end

    always_comb begin
        o_has_result = full || (i_stream_end && (cnt != 3'd0));
        if (full) begin
            o_result.payload_byte  = full_val;
            o_result.byte_complete = 1'b1;
            o_result.final_result  = i_stream_end;
        end else begin
            o_result.payload_byte  = acc;
            o_result.byte_complete = 1'b0;
            o_result.final_result  = 1'b1;
        end

        n_byte_position   = r_byte_position;
        n_bit_accumulator = r_bit_accumulator;
        n_bits_collected  = r_bits_collected;
        if (i_accept) begin
            if (i_stream_end) begin
                n_byte_position   = 3'd0;
                n_bit_accumulator = 8'd0;
                n_bits_collected  = 3'd0;
            end else begin
                n_byte_position   = (pos_inc >= frame_len) ? 3'd0 : pos_inc[2:0];
                n_bit_accumulator = acc;
                n_bits_collected  = cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position   <= 3'd0;
            r_bit_accumulator <= 8'd0;
            r_bits_collected  <= 3'd0;
        end else begin
            r_byte_position   <= n_byte_position;
            r_bit_accumulator <= n_bit_accumulator;
            r_bits_collected  <= n_bits_collected;
        end
    end

endmodule

### src/lsbe_out_reg.sv
// Result register that holds one finished word until the consumer takes it.
module lsbe_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lsbe_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_full_blocked,
    output lsbe_pkg::t_result o_result
);
    import lsbe_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result, n_result;

    always_comb begin
        n_valid  = r_valid;
        n_result = r_result;
        if (i_load) begin
            n_valid  = 1'b1;
            n_result = i_result;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid        = r_valid;
    assign o_full_blocked = r_valid && i_stall;
    assign o_result       = r_result;

endmodule

### src/lsb_stego_bit_extractor_core.sv
// Top level of the LSB steganography bit extractor.
// Takes one audio data word per cycle and packs its hidden bits, most significant
// first, into payload bytes. Every word is handled by the combinational bit
// packer, and each finished byte is loaded into a one-entry result register, so
// the sustained rate is one input word per clock. The input stalls only while the
// result register holds a word that the consumer is stalling. A word with
// stream_end set flushes any partial byte and restarts the stream state.
// Configuration writes take effect at the next clock and leave the stream state.
module lsb_stego_bit_extractor_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_sample_byte,
    input  logic                           i_stream_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_byte_complete,
    output logic                           o_final_result
);
    import lsbe_pkg::*;

    t_cfg    cfg;
    t_result pack_result;
    t_result out_result;
    logic    has_result;
    logic    accept;
    logic    blocked;

    assign o_stall = blocked;
    assign accept  = i_valid && !blocked;

    lsbe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsbe_bit_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (accept),
        .i_sample_byte (i_sample_byte),
        .i_stream_end  (i_stream_end),
        .o_has_result  (has_result),
        .o_result      (pack_result)
    );

    lsbe_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && has_result),
        .i_result       (pack_result),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_full_blocked (blocked),
        .o_result       (out_result)
    );

    assign o_payload_byte  = out_result.payload_byte;
    assign o_byte_complete = out_result.byte_complete;
    assign o_final_result  = out_result.final_result;

endmodule

### src/lsbe_checker.sv
// Port-level assertions for the extractor core, and the bind that attaches them.
module lsbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_payload_byte,
    input logic       o_byte_complete,
    input logic       o_final_result
);

    // A result word waiting under stall must stay put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_payload_byte)))
        else $error("stalled result word changed");

    // The input stalls only when the result register is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // A partial byte appears only as the last word of a stream.
    a_partial_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_complete) |-> o_final_result)
        else $error("partial byte not marked final");

    // A new result word needs an accepted input word on the edge before.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("result word without an accepted input word");

endmodule

bind lsb_stego_bit_extractor_core lsbe_checker u_lsbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_payload_byte  (o_payload_byte),
    .o_byte_complete (o_byte_complete),
    .o_final_result  (o_final_result)
);

### tb/lsbe_payload_tracker.sv
// Watches the extractor's ports, predicts each payload word and compares it with the output.
module lsbe_payload_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [7:0]                      i_sample_byte,
    input  logic                            i_stream_end,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [7:0]                      i_payload_byte,
    input  logic                            i_byte_complete,
    input  logic                            i_final_result,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsbe_pkg::*;

    logic [1:0] take_sel;
    logic       lsbe_on;
    logic [3:0] frame_bytes;

    int         frame_pos;
    logic [7:0] bit_acc;
    int         bits_held;

    t_result    pending_payloads[$];
    int         fail_tally = 0;

    assign o_fail_count = fail_tally;

    // Pulls the hidden bits out of one sample byte and queues the payload word it finishes.
    task automatic unpack_hidden_bits(input logic [7:0] smp, input logic last_word);
        int         nbits;
        int         flen;
        logic [7:0] bits;
        logic       filled;
        logic [7:0] filled_val;
        t_result    word;
        nbits      = 0;
        bits       = '0;
        filled     = 1'b0;
        filled_val = '0;
        if (lsbe_on) begin
            if ((smp | MASK_1BIT) == LSBE_MARK) begin
                nbits = 1;
                bits  = smp & MASK_1BIT;
            end
        end else if (frame_pos == 0) begin
            case (take_sel)
                TAKE_1BIT: begin
                    nbits = 1;
                    bits  = smp & MASK_1BIT;
                end
                TAKE_2BIT: begin
                    nbits = 2;
                    bits  = smp & MASK_2BIT;
                end
                TAKE_4BIT: begin
                    nbits = 4;
                    bits  = smp & MASK_4BIT;
                end
                default: nbits = 0;
            endcase
        end

        for (int i = nbits; i > 0; i--) begin
            bit_acc[3'(7 - bits_held)] = bits[3'(i - 1)];
            bits_held++;
            if (bits_held == 8) begin
                // Bits that spill past a finished byte are lost if this word ends the stream.
                if (!filled) begin
                    filled     = 1'b1;
                    filled_val = bit_acc;
                end
                bit_acc   = '0;
                bits_held = 0;
            end
        end

        if (frame_bytes == 4'd0)
            flen = 1;
        else if (frame_bytes > BPS_MAX)
            flen = int'(BPS_MAX);
        else
            flen = int'(frame_bytes);
        frame_pos++;
        if (frame_pos >= flen)
            frame_pos = 0;

        if (filled) begin
            word.payload_byte  = filled_val;
            word.byte_complete = 1'b1;
            word.final_result  = last_word;
            pending_payloads.push_back(word);
        end else if (last_word && bits_held != 0) begin
            word.payload_byte  = bit_acc;
            word.byte_complete = 1'b0;
            word.final_result  = 1'b1;
            pending_payloads.push_back(word);
        end

        if (last_word) begin
            frame_pos = 0;
            bit_acc   = '0;
            bits_held = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            take_sel    = TAKE_1BIT;
            lsbe_on     = 1'b0;
            frame_bytes = BPS_RESET;
            frame_pos   = 0;
            bit_acc     = '0;
            bits_held   = 0;
            pending_payloads.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TAKE_MODE:        take_sel    = i_cfg_data[1:0];
                    CFG_LSBE_MODE:        lsbe_on     = i_cfg_data[0];
                    CFG_BYTES_PER_SAMPLE: frame_bytes = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                unpack_hidden_bits(i_sample_byte, i_stream_end);
            if (i_out_valid && !i_out_stall) begin
                if (pending_payloads.size() == 0) begin
                    if (fail_tally < 10)
                        $display("unexpected payload word %02h complete %0b final %0b",
                                 i_payload_byte, i_byte_complete, i_final_result);
                    fail_tally++;
                end else begin
                    want = pending_payloads.pop_front();
                    if (want.payload_byte !== i_payload_byte ||
                        want.byte_complete !== i_byte_complete ||
                        want.final_result !== i_final_result) begin
                        if (fail_tally < 10)
                            $display("payload word mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                     want.payload_byte, want.byte_complete, want.final_result,
                                     i_payload_byte, i_byte_complete, i_final_result);
                        fail_tally++;
                    end
                end
            end
        end
        o_outstanding <= pending_payloads.size();
    end

endmodule

### tb/lsb_stego_bit_extractor_core_test.sv
// Stimulus and verdict for the LSB steganography bit extractor core.
module lsb_stego_bit_extractor_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lsbe_pkg::*;

    localparam logic [1:0]           TAKE_NONE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int                   CYCLE_LIMIT    = 200000;
    localparam int                   HOLD_CYCLES    = 150;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            sample_byte = '0;
    logic                  stream_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            payload_byte;
    logic                  byte_complete;
    logic                  final_result;

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_left = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    logic lsbe_now = 1'b0;

    lsb_stego_bit_extractor_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_sample_byte   (sample_byte),
        .i_stream_end    (stream_end),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_payload_byte  (payload_byte),
        .o_byte_complete (byte_complete),
        .o_final_result  (final_result)
    );

    lsbe_payload_tracker tracker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_sample_byte   (sample_byte),
        .i_stream_end    (stream_end),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_payload_byte  (payload_byte),
        .i_byte_complete (byte_complete),
        .i_final_result  (final_result),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lsb_stego_bit_extractor_core verification failed");
            $finish;
        end
    end

    // A toggle of hold_toggle starts one long stall on the result side.
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_word(input logic [7:0] value, input logic last_word);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_byte <= value;
        stream_end  <= last_word;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
    endtask

    // Stops sending, waits for every predicted word, then lets the result register settle.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_LSBE_MODE)
            lsbe_now = val[0];
    endtask

    // In LSBE mode half the bytes are 0xFE or 0xFF so that bits keep coming.
    function automatic logic [7:0] pick_sample();
        if (lsbe_now && $urandom_range(1) == 1)
            return {7'h7F, 1'($urandom_range(1))};
        return 8'($urandom_range(255));
    endfunction

    task automatic send_stream(input int len, input logic with_end);
        for (int i = 0; i < len; i++)
            send_word(pick_sample(), with_end && (i == len - 1));
    endtask

    initial begin
        logic [7:0] lsbe_run[9];
        int         idle_send[4];
        int         idle_recv[4];
        int         phase_words;
        int         len;
        logic [1:0] take;
        logic [3:0] frame;
        lsbe_run  = '{8'hFE, 8'hFF, 8'h7F, 8'hFF, 8'hFE, 8'hFE, 8'hFF, 8'hFF, 8'hFF};
        idle_send = '{0, 60, 0, 35};
        idle_recv = '{0, 0, 60, 35};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four bits per one-byte frame: a full word, then a flushed half word.
        write_reg(CFG_TAKE_MODE, CFG_DATA_W'(TAKE_4BIT));
        write_reg(CFG_BYTES_PER_SAMPLE, 4'd1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hA5, 1'b1);
        settle();

        // The unused take mode gives nothing, so this end has nothing to flush.
        write_reg(CFG_TAKE_MODE, CFG_DATA_W'(TAKE_NONE));
        write_reg(CFG_UNUSED_IDX, 4'hF);
        send_word(8'h3C, 1'b1);
        settle();

        // LSBE with a zero frame size; 0x7F carries no bit.
        write_reg(CFG_LSBE_MODE, 4'd1);
        write_reg(CFG_BYTES_PER_SAMPLE, 4'd0);
        foreach (lsbe_run[i])
            send_word(lsbe_run[i], i == 8);
        settle();

        // Six bits held, then four more with the end: the byte completes and two bits drop.
        write_reg(CFG_LSBE_MODE, 4'd0);
        write_reg(CFG_TAKE_MODE, CFG_DATA_W'(TAKE_1BIT));
        write_reg(CFG_BYTES_PER_SAMPLE, 4'd1);
        send_stream(6, 1'b0);
        settle();
        write_reg(CFG_TAKE_MODE, CFG_DATA_W'(TAKE_4BIT));
        send_word(8'h5A, 1'b1);
        settle();

        // Long hold on the result side while words keep arriving, so the input backs up.
        hold_toggle <= ~hold_toggle;
        send_stream(40, 1'b1);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            phase_words    = 0;
            while (phase_words < 200) begin
                settle();
                take  = ($urandom_range(9) == 0) ? TAKE_NONE : 2'($urandom_range(2));
                frame = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(8, 1));
                write_reg(CFG_TAKE_MODE, CFG_DATA_W'(take));
                write_reg(CFG_LSBE_MODE, ($urandom_range(2) == 0) ? 4'd1 : 4'd0);
                write_reg(CFG_BYTES_PER_SAMPLE, frame);
                if ($urandom_range(15) == 0)
                    write_reg(CFG_UNUSED_IDX, 4'($urandom_range(15)));
                len = $urandom_range(48, 1);
                // Now and then a stream runs on across the next register writes.
                send_stream(len, $urandom_range(15) != 0);
                phase_words += len;
            end
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("lsb_stego_bit_extractor_core verification clean");
        else
            $display("lsb_stego_bit_extractor_core verification failed");
        $finish;
    end

endmodule
